// ===== rtl/odo_pkg.sv =====
// Shared types, constants and helper functions for the wheel encoder odometry block.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package odo_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_TABLE_LEN = 30;
    localparam int STEP_W          = 5;
    localparam int PROD_W          = 66;
    localparam int OPND_W          = 33;
    localparam int ADDR_W          = 3;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    localparam logic [1:0] CMD_LEFT   = 2'd0;
    localparam logic [1:0] CMD_RIGHT  = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic REG_MM_PER_TICK = 1'b0;
    localparam logic REG_TURN_SCALE  = 1'b1;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_q30;
        logic signed [31:0] sin_q30;
    } cordic_rsp_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [31:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            5'd24:   v = 32'sd41;
            5'd25:   v = 32'sd20;
            5'd26:   v = 32'sd10;
            5'd27:   v = 32'sd5;
            5'd28:   v = 32'sd3;
            5'd29:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [31:0] r;
        if (v > PROD_W'(64'sh0000_0000_7FFF_FFFF))
            r = 32'h7FFF_FFFF;
        else if (v < -PROD_W'(64'sh0000_0000_8000_0000))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wheel_encoder_odometry_top.sv =====
// Wheel encoder odometry: tick counters, pose registers, APB registers and the sequencer.
// Depends on odo_pkg, odo_mul (shared multiplier) and odo_cordic (iterative sin/cos).
// Timing: an edge or clear-pose result passes through S_OUT into the output register;
//   a pose update first runs the multiply states and the CORDIC step loop.
// Throughput: one command at a time, as the input stalls outside S_IDLE; an update is
//   held by the CORDIC step loop and the single multiplier.
//   A new command is taken while the previous result waits downstream.
// Reset: rst_n clears counters, pose, heading, both registers and the sequencer at once.
`default_nettype none

module wheel_encoder_odometry_top
    import odo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        command,
    input  wire logic              b_level,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [31:0]     x_mm,
    output logic signed [31:0]     y_mm,
    output logic [31:0]            heading,
    output logic signed [31:0]     left_total,
    output logic signed [31:0]     right_total,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;  // wait for a command
    localparam logic [3:0] S_MDIST = 4'd1;  // multiply tick sum by travel per tick
    localparam logic [3:0] S_MTURN = 4'd2;  // latch distance, multiply tick difference
    localparam logic [3:0] S_HEAD  = 4'd3;  // advance heading, launch CORDIC
    localparam logic [3:0] S_CORD  = 4'd4;  // wait for cos/sin
    localparam logic [3:0] S_MX    = 4'd5;  // multiply distance by cos
    localparam logic [3:0] S_MY    = 4'd6;  // advance x, multiply distance by sin
    localparam logic [3:0] S_POSY  = 4'd7;  // advance y
    localparam logic [3:0] S_OUT   = 4'd8;  // hand the pose to the output register

    logic [3:0]  state_reg, state_next;

    // configuration registers
    logic [23:0] mm_per_tick_reg, mm_per_tick_next;
    logic [23:0] turn_scale_reg, turn_scale_next;

    // odometry state
    logic [31:0] left_count_reg, left_count_next;
    logic [31:0] right_count_reg, right_count_next;
    logic [31:0] prev_left_reg, prev_left_next;
    logic [31:0] prev_right_reg, prev_right_next;
    logic [31:0] pos_x_reg, pos_x_next;
    logic [31:0] pos_y_reg, pos_y_next;
    logic [31:0] heading_reg, heading_next;

    // update working registers
    logic signed [OPND_W-1:0] sum_reg, sum_next;
    logic signed [OPND_W-1:0] diff_reg, diff_next;
    logic signed [31:0]       dist_reg, dist_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] x_out_reg, y_out_reg, head_out_reg, left_out_reg, right_out_reg;
    logic        out_load;

    logic        in_xfer, cfg_write, out_free;
    logic signed [31:0] delta_l, delta_r;
    logic signed [PROD_W-1:0] prod;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [33:0] pos_sum;
    cordic_req_t cordic_req;
    cordic_rsp_t cordic_rsp;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pready    = 1'b1;

    assign delta_l = signed'(left_count_reg - prev_left_reg);
    assign delta_r = signed'(right_count_reg - prev_right_reg);

    // step of the position: product scaled back to Q16.16, plus old position
    assign pos_sum = 34'(signed'(prod >>> 30)) +
                     ((state_reg == S_MY) ? 34'(signed'(pos_x_reg)) : 34'(signed'(pos_y_reg)));

    // register read
    always_comb
    begin
        unique case (paddr[2])
            REG_MM_PER_TICK: prdata = {8'b0, mm_per_tick_reg};
            default:         prdata = {8'b0, turn_scale_reg};
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_MDIST:
            begin
                mul_a = sum_reg;
                mul_b = OPND_W'(mm_per_tick_reg);
            end
            S_MTURN:
            begin
                mul_a = diff_reg;
                mul_b = OPND_W'(turn_scale_reg);
            end
            S_MX:
            begin
                mul_a = OPND_W'(dist_reg);
                mul_b = OPND_W'(cordic_rsp.cos_q30);
            end
            S_MY:
            begin
                mul_a = OPND_W'(dist_reg);
                mul_b = OPND_W'(cordic_rsp.sin_q30);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        mm_per_tick_next = mm_per_tick_reg;
        turn_scale_next  = turn_scale_reg;
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        prev_left_next   = prev_left_reg;
        prev_right_next  = prev_right_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        heading_next     = heading_reg;
        sum_next         = sum_reg;
        diff_next        = diff_reg;
        dist_next        = dist_reg;
        out_valid_next   = out_valid_reg;
        out_load         = 1'b0;
        cordic_req.start = 1'b0;
        cordic_req.angle = heading_reg;

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MM_PER_TICK: mm_per_tick_next = pwdata[23:0];
                default:         turn_scale_next  = pwdata[23:0];
            endcase
        end

        // drop the result once the downstream transfer completes
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_OUT;
                    unique case (command)
                        CMD_LEFT:
                            left_count_next = b_level ? left_count_reg - 32'd1
                                                      : left_count_reg + 32'd1;
                        CMD_RIGHT:
                            right_count_next = b_level ? right_count_reg + 32'd1
                                                       : right_count_reg - 32'd1;
                        CMD_UPDATE:
                        begin
                            sum_next        = OPND_W'(delta_l) + OPND_W'(delta_r);
                            diff_next       = OPND_W'(delta_r) - OPND_W'(delta_l);
                            prev_left_next  = left_count_reg;
                            prev_right_next = right_count_reg;
                            state_next      = S_MDIST;
                        end
                        default:
                        begin
                            left_count_next  = '0;
                            right_count_next = '0;
                            prev_left_next   = '0;
                            prev_right_next  = '0;
                            pos_x_next       = '0;
                            pos_y_next       = '0;
                            heading_next     = '0;
                        end
                    endcase
                end
            end
            S_MDIST:
                state_next = S_MTURN;
            S_MTURN:
            begin
                // half the travel sum, floor, clamped to Q16.16
                dist_next  = signed'(sat32(prod >>> 1));
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                heading_next     = heading_reg + prod[31:0];
                cordic_req.start = 1'b1;
                cordic_req.angle = heading_reg + prod[31:0];
                state_next       = S_CORD;
            end
            S_CORD:
            begin
                if (cordic_rsp.done)
                    state_next = S_MX;
            end
            S_MX:
                state_next = S_MY;
            S_MY:
            begin
                pos_x_next = sat32(PROD_W'(pos_sum));
                state_next = S_POSY;
            end
            S_POSY:
            begin
                pos_y_next = sat32(PROD_W'(pos_sum));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mm_per_tick_reg <= '0;
            turn_scale_reg  <= '0;
            left_count_reg  <= '0;
            right_count_reg <= '0;
            prev_left_reg   <= '0;
            prev_right_reg  <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            heading_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mm_per_tick_reg <= mm_per_tick_next;
            turn_scale_reg  <= turn_scale_next;
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            prev_left_reg   <= prev_left_next;
            prev_right_reg  <= prev_right_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            heading_reg     <= heading_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        diff_reg <= diff_next;
        dist_reg <= dist_next;
        if (out_load)
        begin
            x_out_reg     <= pos_x_reg;
            y_out_reg     <= pos_y_reg;
            head_out_reg  <= heading_reg;
            left_out_reg  <= left_count_reg;
            right_out_reg <= right_count_reg;
        end
    end

    odo_mul u_mul (
        .clk    (clk),
        .opnd_a (mul_a),
        .opnd_b (mul_b),
        .prod   (prod)
    );

    odo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    assign out_valid   = out_valid_reg;
    assign x_mm        = signed'(x_out_reg);
    assign y_mm        = signed'(y_out_reg);
    assign heading     = head_out_reg;
    assign left_total  = signed'(left_out_reg);
    assign right_total = signed'(right_out_reg);

    // an accepted update always starts the multiply chain
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && command == CMD_UPDATE) |=> state_reg == S_MDIST)
        else $error("update transfer did not start the multiply chain");

    // a clear-pose transfer zeroes the pose and counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && command == CMD_CLEAR) |=>
            (pos_x_reg == '0 && pos_y_reg == '0 && heading_reg == '0 &&
             left_count_reg == '0 && right_count_reg == '0))
        else $error("clear pose left state behind");

    // the CORDIC only reports completion while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        cordic_rsp.done |-> state_reg == S_CORD)
        else $error("CORDIC done outside its wait state");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && out_stall) |=> state_reg == S_OUT)
        else $error("result published over a waiting one");

endmodule

`default_nettype wire

// ===== rtl/odo_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on odo_pkg for operand and product widths.
`default_nettype none

module odo_mul
    import odo_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [OPND_W-1:0] opnd_a,
    input  wire logic signed [OPND_W-1:0] opnd_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(opnd_a) * PROD_W'(opnd_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/odo_cordic.sv =====
// Iterative rotation-mode CORDIC: one add/shift step per cycle, then quadrant fold.
// Depends on odo_pkg for the arctangent table, step count and request/response types.
`default_nettype none

module odo_cordic
    import odo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cordic_req_t req,
    output cordic_rsp_t      rsp
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          quad_reg, quad_next;
    logic signed [31:0]  x_reg, x_next;
    logic signed [31:0]  y_reg, y_next;
    logic signed [31:0]  z_reg, z_next;

    logic [31:0]         angle_rnd;
    logic [1:0]          quad_start;
    logic signed [31:0]  sh_x, sh_y, atan_v;

    always_comb
    begin
        angle_rnd  = req.angle + 32'h2000_0000;
        quad_start = angle_rnd[31:30];
        sh_x       = x_reg >>> step_reg;
        sh_y       = y_reg >>> step_reg;
        atan_v     = atan_turn(step_reg);

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quad_next = quad_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (req.start)
        begin
            // split off the nearest quarter turn, keep the signed remainder
            busy_next = 1'b1;
            step_next = '0;
            quad_next = quad_start;
            x_next    = CORDIC_GAIN_Q30;
            y_next    = 32'sd0;
            z_next    = signed'(req.angle - {quad_start, 30'b0});
        end
        else if (busy_reg)
        begin
            if (!z_reg[31])
            begin
                x_next = x_reg - sh_y;
                y_next = y_reg + sh_x;
                z_next = z_reg - atan_v;
            end
            else
            begin
                x_next = x_reg + sh_y;
                y_next = y_reg - sh_x;
                z_next = z_reg + atan_v;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // fold the rotated vector back by the quarter turns taken off
    always_comb
    begin
        rsp.done = done_reg;
        unique case (quad_reg)
            2'd0:
            begin
                rsp.cos_q30 = x_reg;
                rsp.sin_q30 = y_reg;
            end
            2'd1:
            begin
                rsp.cos_q30 = -y_reg;
                rsp.sin_q30 = x_reg;
            end
            2'd2:
            begin
                rsp.cos_q30 = -x_reg;
                rsp.sin_q30 = -y_reg;
            end
            default:
            begin
                rsp.cos_q30 = y_reg;
                rsp.sin_q30 = -x_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for wheel_encoder_odometry_top: encoder edges, pose updates and
// pose clears are driven through the command channel while an in-bench pose predictor
// checks every result transfer. Depends on odo_pkg and the RTL under rtl/.
module tb_top
    import odo_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Generous cap; a correct run needs only a small fraction of it.
    localparam int CYCLE_LIMIT = 400000;

    // arctan(2^-i) in units of 2^-32 turn, for the predictor's CORDIC
    localparam longint ATAN_TURN [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    // One result transfer, field by field
    typedef struct packed {
        logic signed [31:0] x_mm;
        logic signed [31:0] y_mm;
        logic [31:0]        heading;
        logic signed [31:0] left_total;
        logic signed [31:0] right_total;
    } pose_t;

    // One row of the directed table. When reconfig is set, drain and write both
    // scale registers before the command. When typed is set, the expected pose
    // is the one written in the row instead of the predictor's.
    typedef struct {
        logic [1:0]  cmd;
        logic        b;
        bit          reconfig;
        logic [23:0] mm;
        logic [23:0] turn;
        bit          typed;
        pose_t       want;
    } step_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic               b_level;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] x_mm;
    logic signed [31:0] y_mm;
    logic [31:0]        heading;
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state: tick counters, counters at the last update, pose and scales
    logic [31:0] cnt_l = '0;
    logic [31:0] cnt_r = '0;
    logic [31:0] last_l = '0;
    logic [31:0] last_r = '0;
    logic [31:0] pos_x = '0;
    logic [31:0] pos_y = '0;
    logic [31:0] hdg = '0;
    logic [23:0] cfg_mm = '0;
    logic [23:0] cfg_turn = '0;

    pose_t       pending_poses[$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_left = 0;

    // Directed table: reset values first, then both scales at their maximum,
    // then a quarter-turn-friendly turn scale. Counters are typed in where obvious.
    step_row_t dir_rows [0:23] = '{
        // still at reset scales (both zero): counting in both directions per side
        '{CMD_LEFT,   1'b0, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 1, 0}},
        '{CMD_LEFT,   1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 0, 0}},
        '{CMD_LEFT,   1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, -1, 0}},
        '{CMD_RIGHT,  1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, -1, 1}},
        '{CMD_RIGHT,  1'b0, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, -1, 0}},
        '{CMD_RIGHT,  1'b0, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, -1, -1}},
        // zero scales: the update moves nothing and B is ignored
        '{CMD_UPDATE, 1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, -1, -1}},
        '{CMD_CLEAR,  1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 0, 0}},
        '{CMD_UPDATE, 1'b0, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 0, 0}},
        // both scales at maximum
        '{CMD_LEFT,   1'b0, 1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, '{0, 0, 0, 1, 0}},
        '{CMD_LEFT,   1'b0, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 2, 0}},
        '{CMD_RIGHT,  1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 2, 1}},
        '{CMD_RIGHT,  1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 2, 2}},
        '{CMD_UPDATE, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0, '0},
        '{CMD_RIGHT,  1'b1, 1'b0, 24'h0, 24'h0, 1'b0, '0},
        '{CMD_RIGHT,  1'b1, 1'b0, 24'h0, 24'h0, 1'b0, '0},
        '{CMD_LEFT,   1'b1, 1'b0, 24'h0, 24'h0, 1'b0, '0},
        '{CMD_UPDATE, 1'b1, 1'b0, 24'h0, 24'h0, 1'b0, '0},
        '{CMD_UPDATE, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0, '0},
        // clear keeps the registers: a following update still moves nothing
        '{CMD_CLEAR,  1'b0, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 0, 0}},
        '{CMD_UPDATE, 1'b1, 1'b0, 24'h0, 24'h0, 1'b1, '{0, 0, 0, 0, 0}},
        // 1 mm per tick, 1/1024 turn per tick difference
        '{CMD_LEFT,   1'b1, 1'b1, 24'h01_0000, 24'h40_0000, 1'b1, '{0, 0, 0, -1, 0}},
        '{CMD_RIGHT,  1'b1, 1'b0, 24'h0, 24'h0, 1'b0, '0},
        '{CMD_UPDATE, 1'b0, 1'b0, 24'h0, 24'h0, 1'b0, '0}
    };

    wheel_encoder_odometry_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .b_level     (b_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .x_mm        (x_mm),
        .y_mm        (y_mm),
        .heading     (heading),
        .left_total  (left_total),
        .right_total (right_total),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pose predictor
    // ------------------------------------------------------------------

    // Clamp to the signed 32-bit range
    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Q2.30 cos and sin of a binary angle: split off the nearest quarter turn,
    // rotate the signed remainder with CORDIC, then rotate back by the quarter.
    function automatic void quad_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
        logic [1:0]  q;
        logic [31:0] rem;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        int          i;
        q = 2'((ang + 32'h2000_0000) >> 30);
        rem = ang - {q, 30'd0};
        z = longint'($signed(rem));
        x = 64'sd652032874;
        y = 0;
        for (i = 0; i < CORDIC_STEPS && i < 30; i++)
        begin
            // >>> on a signed longint rounds toward minus infinity
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_TURN[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_TURN[i];
            end
            x = nx;
        end
        case (q)
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    // Apply one command to the predictor state and return the pose it shows
    function automatic pose_t advance_pose(input logic [1:0] cmd, input logic b);
        logic [31:0] dl32;
        logic [31:0] dr32;
        longint      dl;
        longint      dr;
        longint      travel;
        longint      c;
        longint      s;
        case (cmd)
            // mirrored sides: B high counts the left wheel down, the right one up
            CMD_LEFT:  cnt_l = b ? cnt_l - 32'd1 : cnt_l + 32'd1;
            CMD_RIGHT: cnt_r = b ? cnt_r + 32'd1 : cnt_r - 32'd1;
            CMD_UPDATE:
            begin
                dl32 = cnt_l - last_l;
                dr32 = cnt_r - last_r;
                dl = longint'($signed(dl32));
                dr = longint'($signed(dr32));
                last_l = cnt_l;
                last_r = cnt_r;
                travel = (dl + dr) * longint'(cfg_mm);
                travel = longint'($signed(clamp32(travel >>> 1)));
                // heading wraps modulo one turn
                hdg = hdg + (dr32 - dl32) * {8'h00, cfg_turn};
                quad_sincos(hdg, c, s);
                pos_x = clamp32(longint'($signed(pos_x)) + ((travel * c) >>> 30));
                pos_y = clamp32(longint'($signed(pos_y)) + ((travel * s) >>> 30));
            end
            default:
            begin
                cnt_l = '0;
                cnt_r = '0;
                last_l = '0;
                last_r = '0;
                pos_x = '0;
                pos_y = '0;
                hdg = '0;
            end
        endcase
        return '{pos_x, pos_y, hdg, cnt_l, cnt_r};
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        // keep the log short if the block is badly broken
        if (mismatch_cnt <= 100)
            $display("%0t ns: MISMATCH %s: got %h, want %h", $time, what, got, want);
    endtask

    // Compare every result transfer with the oldest pending pose
    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_poses.size() == 0)
                report_mismatch("result with nothing pending, x_mm", x_mm, '0);
            else
            begin
                want = pending_poses.pop_front();
                if (x_mm !== want.x_mm)
                    report_mismatch("x_mm", x_mm, want.x_mm);
                if (y_mm !== want.y_mm)
                    report_mismatch("y_mm", y_mm, want.y_mm);
                if (heading !== want.heading)
                    report_mismatch("heading", heading, want.heading);
                if (left_total !== want.left_total)
                    report_mismatch("left_total", left_total, want.left_total);
                if (right_total !== want.right_total)
                    report_mismatch("right_total", right_total, want.right_total);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("wheel_encoder_odometry_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall, plus a long hold-off counted down here
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0)
        begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end
        else
            out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offer one command; once the transfer happens, predict and queue its pose.
    // Valid stays high past the transfer until the next falling edge decides.
    task automatic send_cmd(input logic [1:0] c, input logic b, input bit typed = 1'b0,
                            input pose_t want = '0);
        pose_t p;
        @(negedge clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        b_level <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = advance_pose(c, b);
        pending_poses.push_back(typed ? want : p);
    endtask

    // Drop valid and hold off until every pending pose has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
    endtask

    // Register write (setup, access), then read back in the same way
    task automatic write_reg(input logic idx, input logic [23:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {8'h00, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_MM_PER_TICK)
            cfg_mm = val;
        else
            cfg_turn = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {8'h00, val})
            report_mismatch(idx == REG_MM_PER_TICK ? "read of mm_per_tick"
                                                   : "read of turn_per_tick_diff",
                            prdata, {8'h00, val});
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_scales(input logic [23:0] mm, input logic [23:0] turn);
        write_reg(REG_MM_PER_TICK, mm);
        write_reg(REG_TURN_SCALE, turn);
    endtask

    // Drive both wheels the same way for a number of tick pairs, then update
    task automatic drive_straight(input int pairs, input logic fwd);
        int k;
        for (k = 0; k < pairs; k++)
        begin
            send_cmd(CMD_LEFT, !fwd);
            send_cmd(CMD_RIGHT, fwd);
        end
        send_cmd(CMD_UPDATE, 1'($urandom_range(1)));
    endtask

    // Mostly bursts of edges closed by an update; each wheel keeps a preferred
    // direction per burst so deltas grow. The rest are clears and noise.
    task automatic run_random(input int n_items);
        int         sent;
        int         len;
        int         k;
        int         r;
        logic       lb;
        logic       rb;
        logic [1:0] c;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                send_cmd(CMD_CLEAR, 1'($urandom_range(1)));
                sent++;
            end
            else if (r < 12)
            begin
                send_cmd(2'($urandom_range(3)), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 24);
                lb = 1'($urandom_range(1));
                rb = 1'($urandom_range(1));
                for (k = 0; k < len; k++)
                begin
                    c = $urandom_range(1) ? CMD_RIGHT : CMD_LEFT;
                    // flip the preferred direction now and then
                    send_cmd(c, (c == CMD_RIGHT ? rb : lb) ^ ($urandom_range(9) == 0));
                end
                send_cmd(CMD_UPDATE, 1'($urandom_range(1)));
                sent += len + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_LEFT;
        b_level = 1'b0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // light sender idling, heavy receiver stalls
        tx_idle_pct = 21;
        rx_idle_pct = 74;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].reconfig)
            begin
                drain();
                set_scales(dir_rows[i].mm, dir_rows[i].turn);
            end
            send_cmd(dir_rows[i].cmd, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        end
        drain();

        // random scales, random motion
        set_scales(24'($urandom), 24'($urandom));
        run_random(90);
        drain();

        // Swap the idling sides. Straight runs at the largest travel per tick:
        // 129 pairs overflow the distance; after the clear, the backward runs clamp x at its negative end.
        tx_idle_pct = 74;
        rx_idle_pct = 21;
        set_scales(24'hFF_FFFF, 24'h00_0000);
        drive_straight(129, 1'b1);
        drive_straight(20, 1'b1);
        send_cmd(CMD_CLEAR, 1'($urandom_range(1)));
        drive_straight(129, 1'b0);
        drive_straight(20, 1'b0);
        run_random(20);
        drain();

        // No idling. Hold the result side off for a long stretch while commands
        // keep coming, so the block backs up and stalls its input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_scales(24'($urandom_range(1, 16'hFFFF)), 24'hFF_FFFF);
        rx_hold_req = 300;
        run_random(90);
        drain();

        // let any stray result show up before the verdict
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("wheel_encoder_odometry_top verification clean");
        else
            $display("wheel_encoder_odometry_top verification failed");
        $finish;
    end

endmodule
